// ----- design/tvsa_pkg.sv -----
// Shared types, widths, constants and arctangent table functions for the solid angle block.
`default_nettype none
package tvsa_pkg;

  localparam int COORD_BITS = 32;
  localparam int ANGLE_ITERATIONS = 28;

  localparam int EDGE_W = COORD_BITS + 1;
  localparam int NORM_HI = 18;
  localparam int NORM_W = NORM_HI + 1;
  localparam int SHIFT_W = (EDGE_W > NORM_W) ? EDGE_W : NORM_W;
  localparam int BL_W = $clog2(EDGE_W + 1);
  localparam int PROD_W = 2 * NORM_W;
  localparam int SUM_W = PROD_W + 1;
  localparam int SQ_W = 2 * NORM_W;
  localparam int SQRT_STEPS = NORM_W;
  localparam int LEN_W = NORM_W;
  localparam int LL_W = 2 * LEN_W;
  localparam int L3_W = 3 * LEN_W;
  localparam int NP_W = NORM_W + SUM_W;
  localparam int WIDE_W = 64;
  localparam int ANG_W = 32;
  localparam int ROUND_SH = 11;

  localparam logic signed [ANG_W-1:0] TWO_PI_Q28 = 32'sd1686629713;
  localparam logic signed [ANG_W-1:0] PI_Q28 = 32'sd843314857;

  typedef logic signed [NORM_W-1:0] comp_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] apex_x;
    logic signed [COORD_BITS-1:0] apex_y;
    logic signed [COORD_BITS-1:0] apex_z;
    logic signed [COORD_BITS-1:0] corner_a_x;
    logic signed [COORD_BITS-1:0] corner_a_y;
    logic signed [COORD_BITS-1:0] corner_a_z;
    logic signed [COORD_BITS-1:0] corner_b_x;
    logic signed [COORD_BITS-1:0] corner_b_y;
    logic signed [COORD_BITS-1:0] corner_b_z;
    logic signed [COORD_BITS-1:0] corner_c_x;
    logic signed [COORD_BITS-1:0] corner_c_y;
    logic signed [COORD_BITS-1:0] corner_c_z;
  } tet_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] solid_angle;
    logic degenerate;
  } angle_t;

  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint atan_pow2_60(input int i);
    longint sum;
    longint term;
    int e;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      term = longint'(udiv64(64'd1 << (60 - e), 64'(2 * k + 1)));
      sum = ((k & 1) != 0) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic longint atan_third_60();
    longint t;
    longint sum;
    longint term;
    int k;
    t = longint'(udiv64(64'd1 << 60, 64'd3));
    sum = 0;
    k = 0;
    while (t != 0) begin
      term = longint'(udiv64(64'(t), 64'(2 * k + 1)));
      sum = ((k & 1) != 0) ? sum - term : sum + term;
      t = longint'(udiv64(64'(t), 64'd9));
      k++;
    end
    return sum;
  endfunction

  function automatic longint to40(input longint v);
    return (v + (longint'(1) <<< 19)) >>> 20;
  endfunction

  function automatic longint quarter_60();
    return atan_pow2_60(1) + atan_third_60();
  endfunction

  function automatic longint atan_entry(input int i);
    return (i == 0) ? to40(quarter_60()) : to40(atan_pow2_60(i));
  endfunction

  localparam longint PI40 = to40(4 * quarter_60());

endpackage
`default_nettype wire

// ----- design/tvsa_norm.sv -----
// Edge vectors from the apex and block normalization to a common scale.
`default_nettype none
module tvsa_norm (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  tvsa_pkg::tet_t tet,
  output logic          out_valid,
  output tvsa_pkg::comp_t comp [9]
);
  import tvsa_pkg::*;

  function automatic logic [EDGE_W-1:0] max3(input logic [EDGE_W-1:0] a,
                                             input logic [EDGE_W-1:0] b,
                                             input logic [EDGE_W-1:0] c);
    logic [EDGE_W-1:0] t;
    t = (a > b) ? a : b;
    return (t > c) ? t : c;
  endfunction

  logic [COORD_BITS-1:0] apex [3];
  logic [COORD_BITS-1:0] corner [9];

  assign apex[0] = tet.apex_x;
  assign apex[1] = tet.apex_y;
  assign apex[2] = tet.apex_z;
  assign corner[0] = tet.corner_a_x;
  assign corner[1] = tet.corner_a_y;
  assign corner[2] = tet.corner_a_z;
  assign corner[3] = tet.corner_b_x;
  assign corner[4] = tet.corner_b_y;
  assign corner[5] = tet.corner_b_z;
  assign corner[6] = tet.corner_c_x;
  assign corner[7] = tet.corner_c_y;
  assign corner[8] = tet.corner_c_z;

  logic                     e_v;
  logic [EDGE_W-1:0]        e_edge [9];
  logic                     g_v;
  logic [EDGE_W-1:0]        g_mag [9];
  logic                     g_neg [9];
  logic [EDGE_W-1:0]        g_gmax [3];
  logic                     t_v;
  logic [EDGE_W-1:0]        t_mag [9];
  logic                     t_neg [9];
  logic                     t_rsh;
  logic [BL_W-1:0]          t_amt;

  logic [EDGE_W-1:0]        mag_c [9];
  logic [EDGE_W-1:0]        m;
  logic [BL_W-1:0]          bl;
  logic                     rsh_c;
  logic [BL_W-1:0]          amt_c;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      mag_c[i] = e_edge[i][EDGE_W-1] ? EDGE_W'(-e_edge[i]) : e_edge[i];
    end
  end

  always_comb begin
    m = max3(g_gmax[0], g_gmax[1], g_gmax[2]);
    bl = '0;
    for (int i = 0; i < EDGE_W; i++) begin
      if (m[i]) bl = BL_W'(i + 1);
    end
    if (bl > BL_W'(NORM_HI)) begin
      rsh_c = 1'b1;
      amt_c = bl - BL_W'(NORM_HI);
    end else begin
      rsh_c = 1'b0;
      amt_c = BL_W'(NORM_HI) - bl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      g_v <= 1'b0;
      t_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      e_v <= in_valid;
      g_v <= e_v;
      t_v <= g_v;
      out_valid <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int j = 0; j < 3; j++) begin
          e_edge[3*v+j] <= {corner[3*v+j][COORD_BITS-1], corner[3*v+j]}
                         - {apex[j][COORD_BITS-1], apex[j]};
        end
      end
      for (int i = 0; i < 9; i++) begin
        g_mag[i] <= mag_c[i];
        g_neg[i] <= e_edge[i][EDGE_W-1];
      end
      for (int v = 0; v < 3; v++) begin
        g_gmax[v] <= max3(mag_c[3*v], mag_c[3*v+1], mag_c[3*v+2]);
      end
      t_mag <= g_mag;
      t_neg <= g_neg;
      t_rsh <= rsh_c;
      t_amt <= amt_c;
    end
  end

  logic [SHIFT_W-1:0] sh [9];
  logic [NORM_W-2:0]  mq [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      sh[i] = t_rsh ? (SHIFT_W'(t_mag[i]) >> t_amt) : (SHIFT_W'(t_mag[i]) << t_amt);
      mq[i] = sh[i][NORM_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        comp[i] <= t_neg[i] ? -$signed({1'b0, mq[i]}) : $signed({1'b0, mq[i]});
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/tvsa_terms.sv -----
// Determinant numerator, edge lengths by pipelined square root, and the denominator.
`default_nettype none
module tvsa_terms (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  tvsa_pkg::comp_t comp [9],
  output logic            out_valid,
  output tvsa_pkg::wide_t num,
  output tvsa_pkg::wide_t den
);
  import tvsa_pkg::*;

  localparam int LAST = SQRT_STEPS - 1;

  logic                     p_v;
  logic signed [PROD_W-1:0] p_min [6];
  logic signed [PROD_W-1:0] p_sq [9];
  logic signed [PROD_W-1:0] p_dot [9];
  comp_t                    p_c [3];

  logic                     q_v;
  logic signed [SUM_W-1:0]  q_minor [3];
  logic [SQ_W-1:0]          q_sq [3];
  logic signed [SUM_W-1:0]  q_dot [3];
  comp_t                    q_c [3];

  logic                     sq_v [SQRT_STEPS];
  logic [SQ_W-1:0]          sq_rem [SQRT_STEPS][3];
  logic [SQ_W-1:0]          sq_root [SQRT_STEPS][3];
  logic signed [SUM_W-1:0]  sq_dot [SQRT_STEPS][3];
  logic signed [NP_W-1:0]   pp [3];
  wide_t                    num_d [1:LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      q_v <= 1'b0;
    end else if (en) begin
      p_v <= in_valid;
      q_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_min[0] <= PROD_W'(comp[4]) * PROD_W'(comp[8]);
      p_min[1] <= PROD_W'(comp[5]) * PROD_W'(comp[7]);
      p_min[2] <= PROD_W'(comp[3]) * PROD_W'(comp[8]);
      p_min[3] <= PROD_W'(comp[5]) * PROD_W'(comp[6]);
      p_min[4] <= PROD_W'(comp[3]) * PROD_W'(comp[7]);
      p_min[5] <= PROD_W'(comp[4]) * PROD_W'(comp[6]);
      for (int i = 0; i < 9; i++) begin
        p_sq[i] <= PROD_W'(comp[i]) * PROD_W'(comp[i]);
      end
      for (int j = 0; j < 3; j++) begin
        p_dot[j]   <= PROD_W'(comp[j])   * PROD_W'(comp[3+j]);
        p_dot[3+j] <= PROD_W'(comp[3+j]) * PROD_W'(comp[6+j]);
        p_dot[6+j] <= PROD_W'(comp[6+j]) * PROD_W'(comp[j]);
        p_c[j] <= comp[j];
      end

      q_minor[0] <= SUM_W'(p_min[0]) - SUM_W'(p_min[1]);
      q_minor[1] <= SUM_W'(p_min[2]) - SUM_W'(p_min[3]);
      q_minor[2] <= SUM_W'(p_min[4]) - SUM_W'(p_min[5]);
      for (int v = 0; v < 3; v++) begin
        q_sq[v] <= $unsigned(p_sq[3*v]) + $unsigned(p_sq[3*v+1]) + $unsigned(p_sq[3*v+2]);
        q_dot[v] <= SUM_W'(p_dot[3*v]) + SUM_W'(p_dot[3*v+1]) + SUM_W'(p_dot[3*v+2]);
      end
      q_c <= p_c;

      for (int j = 0; j < 3; j++) begin
        pp[j] <= NP_W'(q_c[j]) * NP_W'(q_minor[j]);
      end
      num_d[1] <= WIDE_W'(pp[0]) - WIDE_W'(pp[1]) + WIDE_W'(pp[2]);
      for (int k = 2; k <= LAST; k++) begin
        num_d[k] <= num_d[k-1];
      end
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic                    v_in;
    logic [SQ_W-1:0]         rem_in [3];
    logic [SQ_W-1:0]         root_in [3];
    logic signed [SUM_W-1:0] dot_in [3];

    if (k == 0) begin : g_src
      assign v_in = q_v;
      assign rem_in = q_sq;
      assign root_in[0] = '0;
      assign root_in[1] = '0;
      assign root_in[2] = '0;
      assign dot_in = q_dot;
    end else begin : g_src
      assign v_in = sq_v[k-1];
      assign rem_in = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign dot_in = sq_dot[k-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= root_in[l] + BIT) begin
            sq_rem[k][l] <= rem_in[l] - (root_in[l] + BIT);
            sq_root[k][l] <= (root_in[l] >> 1) + BIT;
          end else begin
            sq_rem[k][l] <= rem_in[l];
            sq_root[k][l] <= root_in[l] >> 1;
          end
        end
        sq_dot[k] <= dot_in;
      end
    end
  end

  logic [LEN_W-1:0] len [3];
  assign len[0] = sq_root[LAST][0][LEN_W-1:0];
  assign len[1] = sq_root[LAST][1][LEN_W-1:0];
  assign len[2] = sq_root[LAST][2][LEN_W-1:0];

  logic                   l1_v;
  logic [LL_W-1:0]        l1_l01;
  logic [LEN_W-1:0]       l1_len2;
  logic signed [NP_W-1:0] l1_t [3];
  wide_t                  l1_num;
  logic                   l2_v;
  logic [L3_W-1:0]        l2_l012;
  wide_t                  l2_t;
  wide_t                  l2_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_v <= 1'b0;
      l2_v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      l1_v <= sq_v[LAST];
      l2_v <= l1_v;
      out_valid <= l2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_l01 <= LL_W'(len[0]) * LL_W'(len[1]);
      l1_len2 <= len[2];
      l1_t[0] <= NP_W'($signed({1'b0, len[0]})) * NP_W'(sq_dot[LAST][1]);
      l1_t[1] <= NP_W'($signed({1'b0, len[1]})) * NP_W'(sq_dot[LAST][2]);
      l1_t[2] <= NP_W'($signed({1'b0, len[2]})) * NP_W'(sq_dot[LAST][0]);
      l1_num <= num_d[LAST];

      l2_l012 <= L3_W'(l1_l01) * L3_W'(l1_len2);
      l2_t <= WIDE_W'(l1_t[0]) + WIDE_W'(l1_t[1]) + WIDE_W'(l1_t[2]);
      l2_num <= l1_num;

      den <= WIDE_W'($signed({1'b0, l2_l012})) + l2_t;
      num <= l2_num;
    end
  end

endmodule
`default_nettype wire

// ----- design/tvsa_cordic.sv -----
// Pipelined CORDIC vectoring for the arctangent, special cases, rounding and clamp.
`default_nettype none
module tvsa_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  tvsa_pkg::wide_t  num,
  input  tvsa_pkg::wide_t  den,
  output logic             out_valid,
  output tvsa_pkg::angle_t angle
);
  import tvsa_pkg::*;

  localparam int N = ANGLE_ITERATIONS;

  typedef struct packed {
    logic                    deg;
    logic                    hit;
    logic signed [ANG_W-1:0] value;
  } spec_t;

  logic  cv [N+1];
  wide_t cx [N+1];
  wide_t cy [N+1];
  wide_t cz [N+1];
  spec_t csp [N+1];

  logic  nz;
  logic  dz;
  spec_t sp_c;

  always_comb begin
    nz = (num == '0);
    dz = (den == '0);
    sp_c.deg = nz && dz;
    sp_c.hit = nz || dz;
    if (nz && dz) begin
      sp_c.value = '0;
    end else if (nz) begin
      sp_c.value = (den > 0) ? '0 : TWO_PI_Q28;
    end else begin
      sp_c.value = (num > 0) ? PI_Q28 : -PI_Q28;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      csp[0] <= sp_c;
      if (den < 0) begin
        cx[0] <= -den;
        cy[0] <= -num;
        cz[0] <= (num > 0) ? wide_t'(PI40) : -wide_t'(PI40);
      end else begin
        cx[0] <= den;
        cy[0] <= num;
        cz[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    localparam wide_t A = wide_t'(atan_entry(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (en) begin
        cv[i+1] <= cv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        csp[i+1] <= csp[i];
        if (cy[i] > 0) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + A;
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - A;
        end
      end
    end
  end

  wide_t                   zr;
  logic signed [ANG_W-1:0] clamped;

  always_comb begin
    zr = (cz[N] + wide_t'(1024)) >>> ROUND_SH;
    if (zr > WIDE_W'(TWO_PI_Q28)) begin
      clamped = TWO_PI_Q28;
    end else if (zr < -WIDE_W'(TWO_PI_Q28)) begin
      clamped = -TWO_PI_Q28;
    end else begin
      clamped = zr[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle.solid_angle <= csp[N].hit ? csp[N].value : clamped;
      angle.degenerate <= csp[N].deg;
    end
  end

endmodule
`default_nettype wire

// ----- design/tetra_vertex_solid_angle.sv -----
// Top level of the tetrahedron vertex solid angle pipeline.
//
// Input channel tet_valid / tet_ready / tet carries one apex and three corners,
// signed Q16.16. Output channel angle_valid / angle_ready / angle returns the
// solid angle at the apex in Q3.28 radians plus a degenerate flag, one result
// per transfer, in order.
// Throughput: one item per cycle while angle_ready does not hold the pipeline.
// The path from input transfer to output runs through four normalization
// stages, one stage per root bit in the three-lane square root, the product
// stages for the denominator, and one stage per CORDIC step.
// All stages advance together; tet_ready is high whenever the output register
// is empty or being taken. While the receiver holds angle_ready low with a
// result waiting, the whole pipeline holds and nothing is dropped or repeated.
// Reset clears every stage valid bit; the block then accepts at once.
`default_nettype none
module tetra_vertex_solid_angle (
  input  logic             clk,
  input  logic             rst,
  input  logic             tet_valid,
  output logic             tet_ready,
  input  tvsa_pkg::tet_t   tet,
  output logic             angle_valid,
  input  logic             angle_ready,
  output tvsa_pkg::angle_t angle
);
  import tvsa_pkg::*;

  logic  en;
  logic  n_v;
  comp_t comp [9];
  logic  t_v;
  wide_t num;
  wide_t den;

  assign en = !angle_valid || angle_ready;
  assign tet_ready = en;

  tvsa_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (tet_valid),
    .tet       (tet),
    .out_valid (n_v),
    .comp      (comp)
  );

  tvsa_terms u_terms (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (n_v),
    .comp      (comp),
    .out_valid (t_v),
    .num       (num),
    .den       (den)
  );

  tvsa_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (t_v),
    .num       (num),
    .den       (den),
    .out_valid (angle_valid),
    .angle     (angle)
  );

endmodule
`default_nettype wire

// ----- design/tvsa_chk.sv -----
// Port-level checks for the solid angle block and the bind that attaches them.
`default_nettype none
module tvsa_chk (
  input logic             clk,
  input logic             rst,
  input logic             tet_valid,
  input logic             tet_ready,
  input tvsa_pkg::tet_t   tet,
  input logic             angle_valid,
  input logic             angle_ready,
  input tvsa_pkg::angle_t angle
);
  import tvsa_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    angle_valid && !angle_ready |=> angle_valid && $stable(angle))
    else $error("result dropped or changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !angle_valid |-> tet_ready)
    else $error("input held off with empty output");

  a_deg: assert property (@(posedge clk) disable iff (rst)
    angle_valid && angle.degenerate |-> angle.solid_angle == '0)
    else $error("degenerate result with nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> ($signed(angle.solid_angle) <= TWO_PI_Q28)
                 && ($signed(angle.solid_angle) >= -TWO_PI_Q28))
    else $error("angle outside clamp range");

  a_empty: assert property (@(posedge clk)
    rst |=> !angle_valid)
    else $error("result valid right after reset");

endmodule

bind tetra_vertex_solid_angle tvsa_chk u_chk (.*);
`default_nettype wire

// ----- verif/tb_tetra_vertex_solid_angle.sv -----
// Testbench for the tetrahedron vertex solid angle pipeline: directed table plus random tetrahedra.
`timescale 1ns / 100ps
`default_nettype none
module tb_tetra_vertex_solid_angle;
  import tvsa_pkg::*;

  localparam int LATENCY = 30 + ANGLE_ITERATIONS;
  localparam int N_RANDOM = 1700;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;

  typedef struct {
    tet_t   t;
    logic   known;
    angle_t res;
  } vector_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   tet_valid = 1'b0;
  logic   tet_ready;
  tet_t   tet = '0;
  logic   angle_valid;
  logic   angle_ready = 1'b0;
  angle_t angle;

  angle_t  pending_angles[$];
  vector_t vectors[$];
  int      errors = 0;
  int      accepted = 0;
  int      received = 0;
  int      degenerate_seen = 0;
  longint  cycle = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    drained = 1'b0;

  tetra_vertex_solid_angle i_dut (
    .clk(clk), .rst(rst),
    .tet_valid(tet_valid), .tet_ready(tet_ready), .tet(tet),
    .angle_valid(angle_valid), .angle_ready(angle_ready), .angle(angle)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint root_floor(input longint v);
    longint r;
    longint b;
    longint s;
    s = v;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint arc_step(input int i);
    longint term;
    if (i == 0) begin
      longint t;
      longint third;
      int k;
      t = (longint'(1) <<< 60) / 3;
      third = 0;
      k = 0;
      while (t != 0) begin
        term = t / (2 * k + 1);
        third = (k % 2 != 0) ? third - term : third + term;
        t = t / 9;
        k++;
      end
      return third + arc_step_raw(1);
    end
    return arc_step_raw(i);
  endfunction

  function automatic longint arc_step_raw(input int i);
    longint sum;
    longint term;
    int e;
    sum = 0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      term = (longint'(1) <<< (60 - e)) / (2 * k + 1);
      sum = (k % 2 != 0) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  function automatic longint round40(input longint v);
    return (v + (longint'(1) <<< 19)) >>> 20;
  endfunction

  function automatic logic signed [31:0] vector_angle(input longint num, input longint den);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    longint half_turn;
    longint r;
    half_turn = round40(4 * arc_step(0));
    x = den;
    y = num;
    z = 0;
    if (x < 0) begin
      z = (y > 0) ? half_turn : -half_turn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ANGLE_ITERATIONS; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + round40(arc_step(i));
      end else begin
        x = x - ys; y = y + xs; z = z - round40(arc_step(i));
      end
    end
    r = floor_shift(z + 1024, 11);
    if (r > longint'(TWO_PI_Q28)) r = TWO_PI_Q28;
    if (r < -longint'(TWO_PI_Q28)) r = -longint'(TWO_PI_Q28);
    return r[31:0];
  endfunction

  function automatic angle_t predict_angle(input tet_t t);
    longint apex[3];
    longint e[3][3];
    longint pts[9];
    longint m;
    longint q;
    longint num;
    longint den;
    longint ln[3];
    longint d01;
    longint d12;
    longint d20;
    int s;
    angle_t o;
    apex = '{longint'(t.apex_x), longint'(t.apex_y), longint'(t.apex_z)};
    pts = '{longint'(t.corner_a_x), longint'(t.corner_a_y), longint'(t.corner_a_z),
            longint'(t.corner_b_x), longint'(t.corner_b_y), longint'(t.corner_b_z),
            longint'(t.corner_c_x), longint'(t.corner_c_y), longint'(t.corner_c_z)};
    m = 0;
    for (int v = 0; v < 3; v++)
      for (int j = 0; j < 3; j++) begin
        e[v][j] = pts[3 * v + j] - apex[j];
        q = (e[v][j] < 0) ? -e[v][j] : e[v][j];
        if (q > m) m = q;
      end
    if (m >= (longint'(1) <<< 18)) begin
      s = 0;
      while ((m >>> s) >= (longint'(1) <<< 18)) s++;
      for (int v = 0; v < 3; v++)
        for (int j = 0; j < 3; j++) begin
          q = ((e[v][j] < 0) ? -e[v][j] : e[v][j]) >>> s;
          e[v][j] = (e[v][j] < 0) ? -q : q;
        end
    end else if (m > 0) begin
      s = 0;
      while ((m <<< s) < (longint'(1) <<< 17)) s++;
      for (int v = 0; v < 3; v++)
        for (int j = 0; j < 3; j++) e[v][j] = e[v][j] <<< s;
    end
    num = e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
        - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
        + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    for (int v = 0; v < 3; v++)
      ln[v] = root_floor(e[v][0] * e[v][0] + e[v][1] * e[v][1] + e[v][2] * e[v][2]);
    d01 = e[0][0] * e[1][0] + e[0][1] * e[1][1] + e[0][2] * e[1][2];
    d12 = e[1][0] * e[2][0] + e[1][1] * e[2][1] + e[1][2] * e[2][2];
    d20 = e[2][0] * e[0][0] + e[2][1] * e[0][1] + e[2][2] * e[0][2];
    den = ln[0] * ln[1] * ln[2] + ln[0] * d12 + ln[1] * d20 + ln[2] * d01;
    o = '0;
    if (num == 0 && den == 0) o.degenerate = 1'b1;
    else if (num == 0) o.solid_angle = (den > 0) ? 32'sd0 : TWO_PI_Q28;
    else if (den == 0) o.solid_angle = (num > 0) ? PI_Q28 : -PI_Q28;
    else o.solid_angle = vector_angle(num, den);
    return o;
  endfunction

  function automatic tet_t make_tet(input logic signed [31:0] ax, ay, az,
                                    bx, by, bz, cx, cy, cz, dx, dy, dz);
    tet_t t;
    t = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
    return t;
  endfunction

  function automatic logic signed [31:0] rand_coord(input int span);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? CMAX : CMIN;
      2: return $signed($urandom_range(0, 2 * span)) - span;
      default: return $signed($urandom_range(0, 2 * (span << 4))) - (span << 4);
    endcase
  endfunction

  function automatic tet_t rand_tet();
    tet_t t;
    int span;
    logic signed [31:0] base[3];
    span = 1 << $urandom_range(0, 26);
    if ($urandom_range(0, 3) == 0) begin
      t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      for (int j = 0; j < 3; j++) base[j] = rand_coord(1 << 26);
      t.apex_x = base[0]; t.apex_y = base[1]; t.apex_z = base[2];
      t.corner_a_x = base[0] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_a_y = base[1] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_a_z = base[2] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_b_x = base[0] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_b_y = base[1] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_b_z = base[2] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_c_x = base[0] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_c_y = base[1] + ($signed($urandom_range(0, 2 * span)) - span);
      t.corner_c_z = base[2] + ($signed($urandom_range(0, 2 * span)) - span);
      // collapse an edge or make corners coplanar now and then
      case ($urandom_range(0, 7))
        0: begin t.corner_a_x = t.apex_x; t.corner_a_y = t.apex_y; t.corner_a_z = t.apex_z; end
        1: begin t.corner_c_x = t.corner_b_x; t.corner_c_y = t.corner_b_y;
                 t.corner_c_z = t.corner_b_z; end
        2: begin t.corner_a_z = t.apex_z; t.corner_b_z = t.apex_z; t.corner_c_z = t.apex_z; end
        default: ;
      endcase
    end
    return t;
  endfunction

  task automatic send_tet(input tet_t t);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      tet_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    tet <= t;
    tet_valid <= 1'b1;
    @(posedge clk);
    while (!tet_ready) @(posedge clk);
    pending_angles = {pending_angles, predict_angle(t)};
    accepted++;
  endtask

  always @(posedge clk) begin
    if (!rst) angle_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && angle_valid && angle_ready) begin
      received++;
      if (pending_angles.size() == 0) begin
        $error("angle transfer with nothing expected");
        errors++;
      end else begin
        angle_t exp_a;
        exp_a = pending_angles.pop_front();
        if (angle.degenerate) degenerate_seen++;
        if (angle.solid_angle !== exp_a.solid_angle) begin
          $error("solid_angle expected %0d got %0d", exp_a.solid_angle, angle.solid_angle);
          errors++;
        end
        if (angle.degenerate !== exp_a.degenerate) begin
          $error("degenerate expected %0b got %0b", exp_a.degenerate, angle.degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_vector(input tet_t t, input logic known, input logic signed [31:0] sa,
                            input logic dg);
    vector_t v;
    v.t = t;
    v.known = known;
    v.res.solid_angle = sa;
    v.res.degenerate = dg;
    vectors = {vectors, v};
  endtask

  initial begin
    angle_t pred;
    // all at origin, all equal at extremes: degenerate
    add_vector('0, 1'b1, 32'sd0, 1'b1);
    add_vector(make_tet(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX),
               1'b1, 32'sd0, 1'b1);
    add_vector(make_tet(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN),
               1'b1, 32'sd0, 1'b1);
    // coplanar edges pointing away together: zero numerator, positive denominator
    add_vector(make_tet(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 65536, 65536, 0), 1'b1, 32'sd0, 1'b0);
    // coplanar, apex inside the triangle: numerator zero, denominator negative
    add_vector(make_tet(0, 0, 0, 65536, 0, 0, -65536, 65536, 0, -65536, -65536, 0),
               1'b1, TWO_PI_Q28, 1'b0);
    // orthant corner, both orientations
    add_vector(make_tet(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 65536), 1'b0, 0, 0);
    add_vector(make_tet(0, 0, 0, 0, 65536, 0, 65536, 0, 0, 0, 0, 65536), 1'b0, 0, 0);
    // widest edges, opposite extremes
    add_vector(make_tet(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX),
               1'b0, 0, 0);
    add_vector(make_tet(CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN),
               1'b0, 0, 0);
    // tiny edge beside a huge one, then unit-length edges only
    add_vector(make_tet(0, 0, 0, 1, 0, 0, 0, CMAX, 0, 0, 0, CMIN), 1'b0, 0, 0);
    add_vector(make_tet(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1), 1'b0, 0, 0);
    add_vector(make_tet(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0), 1'b0, 0, 0);
    // flat sliver and near-degenerate shapes
    add_vector(make_tet(0, 0, 0, 65536, 0, 0, -65536, 1, 0, 0, -65536, 1), 1'b0, 0, 0);
    add_vector(make_tet(0, 0, 0, 65536, 0, 0, 65536, 1, 0, 65536, 0, 1), 1'b0, 0, 0);
    add_vector(make_tet(5, 7, -3, 5, 7, -3, 100, 200, 300, -4, 9, 1), 1'b0, 0, 0);
    add_vector(make_tet(32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f, 32'sh55555555,
                        32'shaaaaaaaa, 32'sh33333333, 32'shcccccccc, 32'sh00ff00ff,
                        32'shff00ff00, 32'sh7f7f7f7f, 32'sh80808080, 32'sh01010101),
               1'b0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 54;
    foreach (vectors[i]) begin
      if (vectors[i].known) begin
        pred = predict_angle(vectors[i].t);
        if (pred !== vectors[i].res) begin
          $error("table row %0d: predictor gives %0d/%0b", i, pred.solid_angle, pred.degenerate);
          errors++;
        end
      end
      send_tet(vectors[i].t);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 28;
      end
      if (n == 2 * N_RANDOM / 3) begin
        tet_valid <= 1'b0;
        @(posedge clk);
        while (pending_angles.size() != 0) @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_tet(rand_tet());
    end
    tet_valid <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d tetrahedra (%0d degenerate) under three idle mixes.",
             accepted, degenerate_seen);
    $display("Received %0d angle transfers.", received);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
